[rtl/ic_pkg.sv]
// Shared types and constants for the inversion counter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ic_pkg;

	localparam int MAX_ITEMS_DEF = 256;
	localparam int INV_W         = 15;
	localparam logic [INV_W-1:0] TOTAL_MAX = 15'h7FFF;

	// Input beat: one element of the set.
	typedef struct packed {
		logic signed [31:0] value;
		logic               last;
	} item_t;

	// Output beat: one result per set.
	typedef struct packed {
		logic [INV_W-1:0] inversions;
		logic             overflow;
	} result_t;

	// Control that travels with an element along the row of cells.
	typedef struct packed {
		logic valid;
		logic last;
		logic stored;
	} link_ctl_t;

endpackage

`default_nettype wire

[rtl/ic_cell.sv]
// One cell of the row: holds one stored element and counts greater values.
// Depends on ic_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ic_cell #(
	parameter int CW = 8
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     advance,
	input  wire ic_pkg::link_ctl_t        ctl_in,
	input  wire logic signed [31:0]       val_in,
	input  wire logic [CW-1:0]            cnt_in,
	output ic_pkg::link_ctl_t             ctl_out,
	output logic signed [31:0]            val_out,
	output logic [CW-1:0]                 cnt_out
);
	import ic_pkg::*;

	logic signed [31:0] value_q;
	logic               full_q;
	link_ctl_t          ctl_q;
	logic signed [31:0] val_q;
	logic [CW-1:0]      cnt_q;

	logic               greater;
	logic               take;

	assign greater = full_q && (value_q > val_in);
	// first free cell on the beat's way keeps it
	assign take    = ctl_in.valid && !full_q && !ctl_in.stored;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			ctl_q  <= '0;
		end else if (advance) begin
			ctl_q.valid  <= ctl_in.valid;
			ctl_q.last   <= ctl_in.last;
			ctl_q.stored <= ctl_in.stored | take;
			if (ctl_in.valid) begin
				// the last beat of a set empties every cell it passes
				if (ctl_in.last) begin
					full_q <= 1'b0;
				end else if (take) begin
					full_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			val_q <= val_in;
			cnt_q <= cnt_in + CW'(greater);
			if (take) begin
				value_q <= val_in;
			end
		end
	end

	assign ctl_out = ctl_q;
	assign val_out = val_q;
	assign cnt_out = cnt_q;

endmodule

`default_nettype wire

[rtl/ic_total.sv]
// Tail of the row: saturating running total, overflow flag, result register.
// Depends on ic_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ic_total #(
	parameter int CW = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               advance,
	input  wire ic_pkg::link_ctl_t  ctl_in,
	input  wire logic [CW-1:0]      cnt_in,
	output logic                    result_valid,
	output ic_pkg::result_t         result
);
	import ic_pkg::*;

	localparam int SUM_W = ((CW > INV_W) ? CW : INV_W) + 1;

	logic [INV_W-1:0] total_q;
	logic             ovf_q;
	logic             res_valid_q;
	result_t          res_q;

	logic [SUM_W-1:0] sum;
	logic [INV_W-1:0] sat_total;
	logic [INV_W-1:0] next_total;
	logic             next_ovf;

	always_comb begin
		sum = SUM_W'(total_q) + SUM_W'(cnt_in);
		if (sum >= SUM_W'(TOTAL_MAX)) begin
			sat_total = TOTAL_MAX;
		end else begin
			sat_total = sum[INV_W-1:0];
		end
		// a beat that found no free cell only marks overflow
		next_total = ctl_in.stored ? sat_total : total_q;
		next_ovf   = ovf_q | ~ctl_in.stored;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= ctl_in.valid && ctl_in.last;
			if (ctl_in.valid) begin
				if (ctl_in.last) begin
					total_q <= '0;
					ovf_q   <= 1'b0;
				end else begin
					total_q <= next_total;
					ovf_q   <= next_ovf;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ctl_in.valid && ctl_in.last) begin
			res_q.inversions <= next_total;
			res_q.overflow   <= next_ovf;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

`default_nettype wire

[rtl/inversion_counter_top.sv]
// Top level of the inversion counter: a row of MAX_ITEMS cells and a tail.
// Depends on ic_pkg, ic_cell and ic_total.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                          Beat
// item      item_valid / item_stall / item   one element, last marks end of set
// result    result_valid / result_stall /    inversion count and overflow flag,
//           result                           one per set
//
// One element per cycle is taken, back to back, for as long as the result side
// keeps up. Each beat walks the row of cells one cell per cycle while the row
// advances; a result is registered once the last beat of its set leaves the row.
// Reset empties every cell and clears the total; stored values need no reset.
// The whole row holds while a result waits under stall, so item_stall follows
// result_stall whenever the result register is occupied.

module inversion_counter_top #(
	parameter int MAX_ITEMS = ic_pkg::MAX_ITEMS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire ic_pkg::item_t    item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output ic_pkg::result_t       result
);
	import ic_pkg::*;

	localparam int CW = $clog2(MAX_ITEMS);

	logic                advance;
	link_ctl_t           ctl  [0:MAX_ITEMS];
	logic signed [31:0]  val  [0:MAX_ITEMS];
	logic [CW-1:0]       cnt  [0:MAX_ITEMS];

	// the row moves whenever the result register is free or being emptied
	assign advance    = !result_valid || !result_stall;
	assign item_stall = !advance;

	// head of the row: a fresh beat, not yet stored, no comparisons yet
	assign ctl[0].valid  = item_valid;
	assign ctl[0].last   = item.last;
	assign ctl[0].stored = 1'b0;
	assign val[0]        = item.value;
	assign cnt[0]        = '0;

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		ic_cell #(
			.CW (CW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.ctl_in  (ctl[i]),
			.val_in  (val[i]),
			.cnt_in  (cnt[i]),
			.ctl_out (ctl[i+1]),
			.val_out (val[i+1]),
			.cnt_out (cnt[i+1])
		);
	end

	// value leaving the last cell has no further use
	ic_total #(
		.CW (CW)
	) u_total (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance && (val[MAX_ITEMS] == val[MAX_ITEMS] || 1'b1)),
		.ctl_in       (ctl[MAX_ITEMS]),
		.cnt_in       (cnt[MAX_ITEMS]),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

`default_nettype wire
